// ===== sv/ucps_pkg.sv =====
// ---------------------------------------------------------------------------
// UTF-8 code point splitter package
// Shared types and constants for the splitter, its step logic and result queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ucps_pkg;

   // Replacement character U+FFFD, packed first byte high.
   localparam logic [31:0] REPL_BYTES  = 32'hEFBF_BD00;
   localparam logic [2:0]  REPL_LENGTH = 3'd3;

   // Result queue sizing: one item can push two results.
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int unsigned PUSH_MAX   = 2;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic [31:0] unit_bytes;
      logic [2:0]  unit_length;
      logic        replaced;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [23:0] held_bytes;
      logic [1:0]  held_count;
      logic [1:0]  trails_left;
      logic        in_sequence;
      logic        swallow_mode;
   } state_type;

   // Results produced by one item, 0 to 2.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ===== sv/ucps_if.sv =====
// ---------------------------------------------------------------------------
// UTF-8 splitter channels
// Valid/ready channels for the byte input and the code point output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ucps_req_if;
   logic                valid;
   logic                ready;
   ucps_pkg::byte_type  data_byte;
   logic                flush;

   modport source (output valid, output data_byte, output flush, input ready);
   modport sink   (input valid, input data_byte, input flush, output ready);
endinterface

interface ucps_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] unit_bytes;
   logic [2:0]  unit_length;
   logic        replaced;
   logic        last;

   modport source (output valid, output unit_bytes, output unit_length,
                   output replaced, output last, input ready);
   modport sink   (input valid, input unit_bytes, input unit_length,
                   input replaced, input last, output ready);
endinterface

// ===== sv/ucps_step.sv =====
// ---------------------------------------------------------------------------
// UTF-8 splitter step logic
// Decodes one byte against the pending sequence: next state and up to two results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucps_step (
   input  ucps_pkg::state_type state_ff,
   input  ucps_pkg::byte_type  data_byte,
   input  logic                flush,
   output ucps_pkg::state_type state_in,
   output ucps_pkg::push_type  push
);
   import ucps_pkg::*;

   localparam state_type STATE_CLEAR = '0;

   logic       trail;
   logic       lead_emit;
   result_type lead_unit;
   state_type  lead_state;
   result_type repl_unit;
   result_type done_unit;
   logic [23:0] acc_bytes;

   assign trail = (data_byte[7:6] == 2'b10);

   always_comb begin
      repl_unit             = '0;
      repl_unit.unit_bytes  = REPL_BYTES;
      repl_unit.unit_length = REPL_LENGTH;
      repl_unit.replaced    = 1'b1;
   end

   // Byte taken as a new lead, always from a cleared state.
   always_comb begin
      lead_emit  = 1'b0;
      lead_unit  = repl_unit;
      lead_state = STATE_CLEAR;
      if (trail) begin
         lead_emit = 1'b1;
      end else if (!data_byte[7]) begin
         lead_emit             = 1'b1;
         lead_unit             = '0;
         lead_unit.unit_bytes  = {data_byte, 24'h0};
         lead_unit.unit_length = 3'd1;
      end else if (data_byte < 8'hC2 || data_byte > 8'hF4) begin
         lead_state.swallow_mode = 1'b1;
      end else begin
         lead_state.held_bytes  = {data_byte, 16'h0};
         lead_state.held_count  = 2'd1;
         lead_state.in_sequence = 1'b1;
         if (data_byte < 8'hE0) begin
            lead_state.trails_left = 2'd1;
         end else if (data_byte < 8'hF0) begin
            lead_state.trails_left = 2'd2;
         end else begin
            lead_state.trails_left = 2'd3;
         end
      end
   end

   // Trail byte into the pending sequence.
   always_comb begin
      done_unit             = '0;
      done_unit.unit_length = {1'b0, state_ff.held_count} + 3'd1;
      acc_bytes             = state_ff.held_bytes;
      case (state_ff.held_count)
         2'd1: begin
            done_unit.unit_bytes = {state_ff.held_bytes[23:16], data_byte, 16'h0};
            acc_bytes[15:8]      = state_ff.held_bytes[15:8] | data_byte;
         end
         2'd2: begin
            done_unit.unit_bytes = {state_ff.held_bytes[23:8], data_byte, 8'h0};
            acc_bytes[7:0]       = state_ff.held_bytes[7:0] | data_byte;
         end
         2'd3: begin
            done_unit.unit_bytes = {state_ff.held_bytes, data_byte};
         end
         default: begin
            done_unit.unit_bytes = {state_ff.held_bytes[23:16],
                                    state_ff.held_bytes[15:8] | data_byte,
                                    state_ff.held_bytes[7:0], 8'h0};
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      push.count  = 2'd0;
      push.first  = repl_unit;
      push.second = lead_unit;
      if (flush) begin
         state_in = STATE_CLEAR;
         if (state_ff.in_sequence || state_ff.swallow_mode) begin
            push.count = 2'd1;
         end
      end else if (state_ff.swallow_mode || state_ff.in_sequence) begin
         if (!trail) begin
            // Cut short: replacement, then the byte as a new lead.
            state_in   = lead_state;
            push.count = lead_emit ? 2'd2 : 2'd1;
         end else if (state_ff.in_sequence) begin
            if (state_ff.trails_left <= 2'd1) begin
               state_in    = STATE_CLEAR;
               push.count  = 2'd1;
               push.first  = done_unit;
            end else begin
               state_in.held_bytes  = acc_bytes;
               state_in.held_count  = state_ff.held_count + 2'd1;
               state_in.trails_left = state_ff.trails_left - 2'd1;
            end
         end
      end else begin
         state_in    = lead_state;
         push.count  = {1'b0, lead_emit};
         push.first  = lead_unit;
      end
      push.first.last  = (push.count == 2'd1);
      push.second.last = 1'b1;
   end

endmodule

// ===== sv/ucps_fifo.sv =====
// ---------------------------------------------------------------------------
// UTF-8 splitter result queue
// Small register queue taking up to two results per cycle, one out per cycle while out_ready is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucps_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  ucps_pkg::push_type   push,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output ucps_pkg::result_type out_data
);
   import ucps_pkg::*;

   result_type       mem [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   logic [PTR_W-1:0] wr_next;

   assign room      = (count_ff <= CNT_W'(FIFO_DEPTH - PUSH_MAX));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign wr_next   = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.second;
      end
   end

endmodule

// ===== sv/utf8_code_point_splitter.sv =====
// Accepted bytes push their results into the registered queue that drives rsp.
// Throughput: one byte per cycle while rsp is ready and each byte gives at most
//   one result; a byte that gives two results sends them in turn on the single result port.
// The four-entry result queue takes a byte only with two free entries.
// Reset (synchronous, active high) clears the pending sequence and the queue.
// ---------------------------------------------------------------------------
// UTF-8 code point splitter
// Splits a UTF-8 byte stream into packed code points, replacing bad input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_code_point_splitter (
   input logic        clock,
   input logic        reset,
   ucps_req_if.sink   req_chan,
   ucps_rsp_if.source rsp_chan
);
   import ucps_pkg::*;

   // Decode state: held lead/trail bytes, trails still expected, and the
   // swallow flag that eats trail bytes after an invalid lead.
   state_type  state_ff;
   state_type  state_in;
   state_type  state_next;
   push_type   step_push;
   push_type   push;
   logic       room;
   logic       req_accept;
   result_type rsp_data;

   // Queue always keeps room for the two results a cut-short byte can give,
   // so ready does not depend on the sink in the same cycle.
   assign req_chan.ready = room;
   assign req_accept     = req_chan.valid && room;

   ucps_step u_step (
      .state_ff  (state_ff),
      .data_byte (req_chan.data_byte),
      .flush     (req_chan.flush),
      .state_in  (state_next),
      .push      (step_push)
   );

   // State changes and queue pushes only happen on an accepted item.
   always_comb begin
      state_in   = state_ff;
      push       = step_push;
      push.count = 2'd0;
      if (req_accept) begin
         state_in   = state_next;
         push.count = step_push.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   ucps_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   assign rsp_chan.unit_bytes  = rsp_data.unit_bytes;
   assign rsp_chan.unit_length = rsp_data.unit_length;
   assign rsp_chan.replaced    = rsp_data.replaced;
   assign rsp_chan.last        = rsp_data.last;

endmodule

// ===== tb/ucps_checker.sv =====
// ---------------------------------------------------------------------------
// UTF-8 splitter checker
// Watches both channels, predicts the code point items and compares them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucps_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  ucps_pkg::byte_type  req_data_byte,
   input  logic                req_flush,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [31:0]         rsp_unit_bytes,
   input  logic [2:0]          rsp_unit_length,
   input  logic                rsp_replaced,
   input  logic                rsp_last,
   output int                  fail_count,
   output int                  pending_count,
   output int                  byte_count,
   output int                  unit_count,
   output int                  repl_count,
   output int                  double_count
);
   import ucps_pkg::*;

   localparam byte_type LEAD_MIN  = 8'hC2;
   localparam byte_type LEAD_MAX  = 8'hF4;
   localparam byte_type LEAD3_MIN = 8'hE0;
   localparam byte_type LEAD4_MIN = 8'hF0;
   localparam int       SHOW_MAX  = 50;

   result_type expected_units [$];
   state_type  seq_state;
   int         shown;

   function automatic void queue_unit(logic [31:0] bytes, logic [2:0] len, logic repl);
      result_type unit;
      unit.unit_bytes  = bytes;
      unit.unit_length = len;
      unit.replaced    = repl;
      unit.last        = 1'b0;
      expected_units.insert(expected_units.size(), unit);
   endfunction

   function automatic void take_lead_byte(byte_type b);
      if (b[7:6] == 2'b10) begin
         queue_unit(REPL_BYTES, REPL_LENGTH, 1'b1);
      end else if (!b[7]) begin
         queue_unit({b, 24'h0}, 3'd1, 1'b0);
      end else if (b < LEAD_MIN || b > LEAD_MAX) begin
         seq_state.swallow_mode = 1'b1;
      end else begin
         seq_state.held_bytes  = {b, 16'h0};
         seq_state.held_count  = 2'd1;
         seq_state.trails_left = (b < LEAD3_MIN) ? 2'd1 : (b < LEAD4_MIN) ? 2'd2 : 2'd3;
         seq_state.in_sequence = 1'b1;
      end
   endfunction

   // One accepted byte: appends 0 to 2 expected items and marks the last.
   function automatic void split_byte(byte_type b, logic flush_in);
      logic        trail_in;
      logic [31:0] wide_b;
      logic [31:0] merged;
      int          shift;
      int          start_size;
      int          tail_idx;
      result_type  tail;
      trail_in   = (b[7:6] == 2'b10);
      wide_b     = {24'h0, b};
      start_size = expected_units.size();
      if (flush_in) begin
         if (seq_state.in_sequence || seq_state.swallow_mode)
            queue_unit(REPL_BYTES, REPL_LENGTH, 1'b1);
         seq_state = '0;
      end else if (seq_state.swallow_mode) begin
         if (!trail_in) begin
            queue_unit(REPL_BYTES, REPL_LENGTH, 1'b1);
            seq_state = '0;
            take_lead_byte(b);
         end
      end else if (seq_state.in_sequence) begin
         if (trail_in) begin
            shift = (seq_state.held_count >= 2'd1) ? 24 - 8 * seq_state.held_count : 16;
            if (seq_state.trails_left <= 2'd1) begin
               merged = {seq_state.held_bytes, 8'h00} | (wide_b << shift);
               queue_unit(merged, {1'b0, seq_state.held_count} + 3'd1, 1'b0);
               seq_state = '0;
            end else begin
               merged = {8'h00, seq_state.held_bytes};
               if (shift >= 8)
                  merged = merged | (wide_b << (shift - 8));
               seq_state.held_bytes  = merged[23:0];
               seq_state.held_count  = seq_state.held_count + 2'd1;
               seq_state.trails_left = seq_state.trails_left - 2'd1;
            end
         end else begin
            queue_unit(REPL_BYTES, REPL_LENGTH, 1'b1);
            seq_state = '0;
            take_lead_byte(b);
         end
      end else begin
         take_lead_byte(b);
      end
      if (expected_units.size() > start_size) begin
         tail_idx                 = expected_units.size() - 1;
         tail                     = expected_units[tail_idx];
         tail.last                = 1'b1;
         expected_units[tail_idx] = tail;
      end
   endfunction

   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      logic       bad;
      int         start_size;
      bad = 1'b0;
      if (reset) begin
         expected_units.delete();
         seq_state     = '0;
         shown         = 0;
         fail_count    <= 0;
         pending_count <= 0;
         byte_count    <= 0;
         unit_count    <= 0;
         repl_count    <= 0;
         double_count  <= 0;
      end else begin
         // Results first: a byte accepted at this edge cannot have one out yet.
         if (rsp_valid && rsp_ready) begin
            got.unit_bytes  = rsp_unit_bytes;
            got.unit_length = rsp_unit_length;
            got.replaced    = rsp_replaced;
            got.last        = rsp_last;
            unit_count <= unit_count + 1;
            if (expected_units.size() == 0) begin
               bad = 1'b1;
               if (shown < SHOW_MAX)
                  $display("%0t: unexpected item: bytes=%h len=%0d repl=%b last=%b",
                           $realtime, got.unit_bytes, got.unit_length, got.replaced,
                           got.last);
            end else begin
               want = expected_units.pop_front();
               if (want.replaced)
                  repl_count <= repl_count + 1;
               if (got !== want) begin
                  bad = 1'b1;
                  if (shown < SHOW_MAX)
                     $display({"%0t: mismatch: expected bytes=%h len=%0d repl=%b last=%b,",
                               " actual bytes=%h len=%0d repl=%b last=%b"},
                              $realtime, want.unit_bytes, want.unit_length, want.replaced,
                              want.last, got.unit_bytes, got.unit_length, got.replaced,
                              got.last);
               end
            end
            if (bad) begin
               shown = shown + 1;
               if (shown == SHOW_MAX)
                  $display("%0t: further mismatches counted but not shown", $realtime);
            end
         end
         if (req_valid && req_ready) begin
            start_size = expected_units.size();
            split_byte(req_data_byte, req_flush);
            byte_count <= byte_count + 1;
            if (expected_units.size() - start_size == 2)
               double_count <= double_count + 1;
         end
         fail_count    <= fail_count + bad;
         pending_count <= expected_units.size();
      end
   end

endmodule

// ===== tb/tb_utf8_code_point_splitter.sv =====
// ---------------------------------------------------------------------------
// UTF-8 splitter testbench
// Directed and random byte streams with random stalls on both channels; a
// checker beside the block predicts every code point item and compares it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_utf8_code_point_splitter;
   import ucps_pkg::*;

   localparam int RESET_CYCLES = 5;
   localparam int ITEM_TARGET  = 550;  // directed part plus about 525 random
   localparam int QUIET_LIMIT  = 1000; // cycles with no handshake at all
   localparam int DRAIN_CYCLES = 12;

   // First and last bytes of each lead class and of the trail range.
   localparam byte_type ASCII_MAX  = 8'h7F;
   localparam byte_type TRAIL_MIN  = 8'h80;
   localparam byte_type TRAIL_MAX  = 8'hBF;
   localparam byte_type BAD_LO_MIN = 8'hC0;
   localparam byte_type BAD_LO_MAX = 8'hC1;
   localparam byte_type LEAD2_MIN  = 8'hC2;
   localparam byte_type LEAD2_MAX  = 8'hDF;
   localparam byte_type LEAD3_MIN  = 8'hE0;
   localparam byte_type LEAD3_MAX  = 8'hEF;
   localparam byte_type LEAD4_MIN  = 8'hF0;
   localparam byte_type LEAD4_MAX  = 8'hF4;
   localparam byte_type BAD_HI_MIN = 8'hF5;
   localparam byte_type BAD_HI_MAX = 8'hFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic idle_on;       // random stalls enabled on both sides
   int   sent_items;
   int   quiet_cycles;

   int fail_count;
   int pending_count;
   int byte_count;
   int unit_count;
   int repl_count;
   int double_count;

   ucps_req_if req_chan ();
   ucps_rsp_if rsp_chan ();

   always #1 clock = ~clock;

   utf8_code_point_splitter i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ucps_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_data_byte   (req_chan.data_byte),
      .req_flush       (req_chan.flush),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_unit_bytes  (rsp_chan.unit_bytes),
      .rsp_unit_length (rsp_chan.unit_length),
      .rsp_replaced    (rsp_chan.replaced),
      .rsp_last        (rsp_chan.last),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .byte_count      (byte_count),
      .unit_count      (unit_count),
      .repl_count      (repl_count),
      .double_count    (double_count)
   );

   // Watchdog: a stretch with no handshake on either channel means a hang.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $realtime, quiet_cycles);
         $display("tb_utf8_code_point_splitter NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: ready toggles in random bursts while stalls are enabled,
   // otherwise it stays high.
   initial begin : rsp_stall
      int span;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            span = $urandom_range(1, 18);
         end else begin
            rsp_chan.ready <= 1'b1;
            span = $urandom_range(1, 12);
         end
         repeat (span) @(posedge clock);
      end
   end

   // Presents one item and returns at the edge where it is taken. valid is
   // left high so a back-to-back item needs no second assignment.
   task automatic send_item(input byte_type b, input logic f);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      req_chan.flush     <= f;
      sent_items = sent_items + 1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Sender holds off until the checker has seen every predicted item.
   // pending_count is registered in the checker, so the task waits on the clock before looking.
   task automatic hold_until_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic byte_type pick(input byte_type lo, input byte_type hi);
      return byte_type'($urandom_range(lo, hi));
   endfunction

   task automatic send_trails(input int n);
      repeat (n) send_item(pick(TRAIL_MIN, TRAIL_MAX), 1'b0);
   endtask

   // One random group. Mostly well-formed code points with random content,
   // the rest stray trails, cut-short sequences, bad leads, flushes, noise.
   task automatic send_random_group();
      int       kind;
      int       need;
      byte_type lead;
      kind = $urandom_range(0, 99);
      if (kind < 38) begin
         send_item(pick(8'h00, ASCII_MAX), 1'b0);
      end else if (kind < 53) begin
         send_item(pick(LEAD2_MIN, LEAD2_MAX), 1'b0);
         send_trails(1);
      end else if (kind < 67) begin
         send_item(pick(LEAD3_MIN, LEAD3_MAX), 1'b0);
         send_trails(2);
      end else if (kind < 78) begin
         send_item(pick(LEAD4_MIN, LEAD4_MAX), 1'b0);
         send_trails(3);
      end else if (kind < 82) begin
         // stray trail bytes with nothing pending
         send_trails($urandom_range(1, 3));
      end else if (kind < 88) begin
         // a valid lead cut short, either by the next group or by a flush
         need = $urandom_range(1, 3);
         lead = (need == 1) ? pick(LEAD2_MIN, LEAD2_MAX) :
                (need == 2) ? pick(LEAD3_MIN, LEAD3_MAX) : pick(LEAD4_MIN, LEAD4_MAX);
         send_item(lead, 1'b0);
         send_trails($urandom_range(0, need - 1));
         if ($urandom_range(0, 1) == 0)
            send_item(pick(8'h00, 8'hFF), 1'b1);
      end else if (kind < 93) begin
         // invalid lead swallowing a few trails
         lead = ($urandom_range(0, 1) == 0) ? pick(BAD_LO_MIN, BAD_LO_MAX) :
                                              pick(BAD_HI_MIN, BAD_HI_MAX);
         send_item(lead, 1'b0);
         send_trails($urandom_range(0, 3));
      end else if (kind < 96) begin
         send_item(pick(8'h00, 8'hFF), 1'b1);
      end else begin
         send_item(pick(8'h00, 8'hFF), 1'b0);
      end
   endtask

   initial begin : stimulus
      logic want_idle;
      req_chan.valid     <= 1'b0;
      req_chan.data_byte <= '0;
      req_chan.flush     <= 1'b0;
      idle_on            <= 1'b1;
      sent_items = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: ASCII extremes
      send_item(8'h00, 1'b0);
      send_item(ASCII_MAX, 1'b0);
      // lowest and highest two-byte codes, lowest three-byte and highest four-byte code
      send_item(LEAD2_MIN, 1'b0);
      send_item(TRAIL_MIN, 1'b0);
      send_item(LEAD2_MAX, 1'b0);
      send_item(TRAIL_MAX, 1'b0);
      send_item(LEAD3_MIN, 1'b0);
      send_item(8'hA0, 1'b0);
      send_item(TRAIL_MIN, 1'b0);
      send_item(LEAD4_MAX, 1'b0);
      send_item(8'h8F, 1'b0);
      send_item(TRAIL_MAX, 1'b0);
      send_item(TRAIL_MAX, 1'b0);
      // stray trail with nothing pending
      send_item(TRAIL_MIN, 1'b0);
      // three-byte lead cut by another lead, then that one cut by ASCII:
      // the second cut gives a replacement and the ASCII item together
      send_item(8'hE5, 1'b0);
      send_item(8'hC3, 1'b0);
      send_item(8'h41, 1'b0);
      // invalid lead eats a trail; the next bad lead ends it and starts anew
      send_item(BAD_LO_MIN, 1'b0);
      send_item(TRAIL_MAX, 1'b0);
      send_item(BAD_HI_MAX, 1'b0);
      // flush during swallow, then flush with nothing pending
      send_item(8'h55, 1'b1);
      send_item(8'hAA, 1'b1);
      // four-byte lead left pending and flushed
      send_item(LEAD4_MIN, 1'b0);
      send_item(8'h90, 1'b0);
      send_item(8'hFF, 1'b1);
      hold_until_drained();

      // Random part. Stalls on, then a stretch without, then on again, and
      // none for the final stretch.
      while (sent_items < ITEM_TARGET) begin
         want_idle = !((sent_items >= 250 && sent_items < 330) ||
                       sent_items >= ITEM_TARGET - 80);
         if (idle_on != want_idle)
            idle_on <= want_idle;
         send_random_group();
         if ($urandom_range(0, 49) == 0)
            hold_until_drained();
      end
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d bytes giving %0d code point items, %0d of them replacements,",
               byte_count, unit_count, repl_count);
      $display("with %0d bytes that each gave two items; %0d failures seen.",
               double_count, fail_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_utf8_code_point_splitter OK");
      end else begin
         $display("tb_utf8_code_point_splitter NOT OK");
      end
      $finish;
   end

endmodule

// ===== utf8_code_point_splitter.f =====
sv/ucps_pkg.sv
sv/ucps_if.sv
sv/ucps_step.sv
sv/ucps_fifo.sv
sv/utf8_code_point_splitter.sv
tb/ucps_checker.sv
tb/tb_utf8_code_point_splitter.sv
